>>> rtl/core/shtlp_pkg.sv
// Package for the linear-probe name hash table: field widths, status codes,
// microcode step and condition codes, and the read-only control program.
// No dependencies; every other file of the block imports it.
package shtlp_pkg;

    localparam int CHAR_W     = 8;
    localparam int SUM_W      = 13;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 6;

    localparam int DEF_SLOTS        = 10;
    localparam int DEF_MAX_NAME_LEN = 19;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;

    // Steps of the control program.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_REM,
        S_START,
        S_INS,
        S_COPY,
        S_SRCH,
        S_SLEN,
        S_SCMP,
        S_SADV,
        S_EMIT
    } t_step;

    // Branch conditions that a control word can test.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ACC_LAST,
        C_TOO_LONG,
        C_OP_SEARCH,
        C_SLOT_FREE,
        C_WRAP,
        C_LEN_NE,
        C_CHAR_NE,
        C_IDX_END,
        C_OUT_FREE
    } t_cond;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic acc_last;
        logic too_long;
        logic op_search;
        logic slot_free;
        logic wrap;
        logic len_ne;
        logic char_ne;
        logic idx_end;
        logic out_free;
    } t_flags;

    // Datapath controls for the current step.
    typedef struct packed {
        logic    accept;
        logic    mul;
        logic    rem;
        logic    start;
        logic    adv;
        logic    wr;
        logic    idx_clr;
        logic    idx_inc;
        logic    emit;
        logic    st_load;
        t_status st;
    } t_ctl;

    // One control word: two prioritized conditional jumps and a fall-through.
    // The probe advance is applied only when neither jump is taken.
    typedef struct packed {
        t_cond   ca;
        t_step   ta;
        t_status sa;
        t_cond   cb;
        t_step   tb;
        t_status sb;
        t_step   tn;
        logic    accept;
        logic    mul;
        logic    rem;
        logic    start;
        logic    adv;
        logic    wr;
        logic    idx_clr;
        logic    idx_inc;
        logic    emit;
    } t_uword;

    function automatic logic f_cond(input t_cond c, input t_flags f);
        logic r;
        begin
            unique case (c)
                C_ACC_LAST:  r = f.acc_last;
                C_TOO_LONG:  r = f.too_long;
                C_OP_SEARCH: r = f.op_search;
                C_SLOT_FREE: r = f.slot_free;
                C_WRAP:      r = f.wrap;
                C_LEN_NE:    r = f.len_ne;
                C_CHAR_NE:   r = f.char_ne;
                C_IDX_END:   r = f.idx_end;
                C_OUT_FREE:  r = f.out_free;
                default:     r = 1'b0;
            endcase
            return r;
        end
    endfunction

    // The control program.
    function automatic t_uword f_uprog(input t_step s);
        t_uword w;
        begin
            w    = '0;
            w.tn = S_IDLE;
            unique case (s)
                S_IDLE: begin
                    w.accept = 1'b1;
                    w.ca     = C_ACC_LAST;
                    w.ta     = S_MUL;
                    w.tn     = S_IDLE;
                end
                S_MUL: begin
                    w.mul = 1'b1;
                    w.tn  = S_REM;
                end
                S_REM: begin
                    w.rem = 1'b1;
                    w.tn  = S_START;
                end
                S_START: begin
                    w.start = 1'b1;
                    w.ca    = C_TOO_LONG;
                    w.ta    = S_EMIT;
                    w.sa    = ST_TOO_LONG;
                    w.cb    = C_OP_SEARCH;
                    w.tb    = S_SRCH;
                    w.tn    = S_INS;
                end
                S_INS: begin
                    w.adv = 1'b1;
                    w.ca  = C_SLOT_FREE;
                    w.ta  = S_COPY;
                    w.sa  = ST_INSERTED;
                    w.cb  = C_WRAP;
                    w.tb  = S_EMIT;
                    w.sb  = ST_FULL;
                    w.tn  = S_INS;
                end
                S_COPY: begin
                    w.wr      = 1'b1;
                    w.idx_inc = 1'b1;
                    w.ca      = C_IDX_END;
                    w.ta      = S_EMIT;
                    w.sa      = ST_INSERTED;
                    w.tn      = S_COPY;
                end
                S_SRCH: begin
                    w.idx_clr = 1'b1;
                    w.ca      = C_SLOT_FREE;
                    w.ta      = S_EMIT;
                    w.sa      = ST_NOT_FOUND;
                    w.tn      = S_SLEN;
                end
                S_SLEN: begin
                    w.ca = C_LEN_NE;
                    w.ta = S_SADV;
                    w.tn = S_SCMP;
                end
                S_SCMP: begin
                    w.idx_inc = 1'b1;
                    w.ca      = C_CHAR_NE;
                    w.ta      = S_SADV;
                    w.cb      = C_IDX_END;
                    w.tb      = S_EMIT;
                    w.sb      = ST_FOUND;
                    w.tn      = S_SCMP;
                end
                S_SADV: begin
                    w.adv = 1'b1;
                    w.ca  = C_WRAP;
                    w.ta  = S_EMIT;
                    w.sa  = ST_NOT_FOUND;
                    w.tn  = S_SRCH;
                end
                S_EMIT: begin
                    w.emit = 1'b1;
                    w.ca   = C_OUT_FREE;
                    w.ta   = S_IDLE;
                    w.tn   = S_EMIT;
                end
                default: begin
                    w.tn = S_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

>>> rtl/core/shtlp_if.sv
// Valid/ready channel interfaces for the name hash table: the request channel
// that carries name characters and the response channel that carries results.
// Depends on shtlp_pkg for the field widths.
interface shtlp_req_if;
    import shtlp_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [CHAR_W-1:0] character;
    logic              last_char;

    modport source (output valid, op, character, last_char, input ready);
    modport sink   (input valid, op, character, last_char, output ready);
endinterface

interface shtlp_rsp_if;
    import shtlp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [SLOT_OUT_W-1:0] home_key;

    modport source (output valid, status, slot, home_key, input ready);
    modport sink   (input valid, status, slot, home_key, output ready);
endinterface

>>> rtl/core/shtlp_seq.sv
// Microcode sequencer of the name hash table: step register, control ROM
// lookup and two-way conditional branching on datapath flags.
// Depends on shtlp_pkg for the step codes, control words and the program.
module shtlp_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  shtlp_pkg::t_flags i_flags,
    output shtlp_pkg::t_ctl   o_ctl
);
    import shtlp_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword uw;
    logic   take_a;
    logic   take_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        uw     = f_uprog(r_step);
        take_a = f_cond(uw.ca, i_flags);
        take_b = !take_a && f_cond(uw.cb, i_flags);

        if (take_a) begin
            n_step = uw.ta;
        end else if (take_b) begin
            n_step = uw.tb;
        end else begin
            n_step = uw.tn;
        end

        o_ctl.accept  = uw.accept;
        o_ctl.mul     = uw.mul;
        o_ctl.rem     = uw.rem;
        o_ctl.start   = uw.start;
        o_ctl.adv     = uw.adv && !take_a && !take_b;
        o_ctl.wr      = uw.wr;
        o_ctl.idx_clr = uw.idx_clr;
        o_ctl.idx_inc = uw.idx_inc;
        o_ctl.emit    = uw.emit;
        o_ctl.st_load = take_a || take_b;
        o_ctl.st      = take_a ? uw.sa : uw.sb;
    end

endmodule

>>> rtl/core/string_hash_table_linear_probe.sv
// Name hash table with linear probing. Name characters are accepted while it is idle.
// After the last character the home slot is computed (multiply, then subtract). An
// insert probes from there to the first free slot and copies the name into it, or
// reports full after a lap; a search compares the stored length, then the characters,
// of each occupied slot and ends on a match, a free slot or a lap. The result is then
// loaded, later while the previous result waits. A too-long name skips the probe.
// The next name is accepted once the result is loaded.
// Synchronous active-low reset empties the table (valid flags) and the name state.
// Depends on shtlp_pkg, shtlp_if (request/response channels) and shtlp_seq.
module string_hash_table_linear_probe #(
    parameter int SLOTS        = shtlp_pkg::DEF_SLOTS,
    parameter int MAX_NAME_LEN = shtlp_pkg::DEF_MAX_NAME_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    shtlp_req_if.sink   i_req,
    shtlp_rsp_if.source o_rsp
);
    import shtlp_pkg::*;

    // Slot index width, name length / character index width and the
    // address width of the stored-name memory (one row per slot).
    localparam int SW = $clog2(SLOTS);
    localparam int LW = $clog2(MAX_NAME_LEN + 1);
    localparam int AW = SW + LW;

    // The home slot is sum mod SLOTS. The quotient comes from a multiply by
    // a rounded-up reciprocal; with a 13-bit sum and at most 64 slots the
    // extra 7 fraction bits make the quotient exact, so no correction step.
    localparam int             SH     = SUM_W + 7;
    localparam int             PW     = SUM_W + SH + 1;
    localparam logic [SH:0]    RECIP  = (SH + 1)'((1 << SH) / SLOTS + 1);
    localparam logic [SUM_W-1:0] SLOTS_S = SUM_W'(SLOTS);
    localparam logic [SW-1:0]  LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [LW-1:0]  MAX_LEN   = LW'(MAX_NAME_LEN);

    t_ctl   ctl;
    t_flags flags;

    // Name being received.
    logic [CHAR_W-1:0] r_buf [0:(1 << LW)-1];
    logic [LW-1:0]     r_len;
    logic [SUM_W-1:0]  r_sum;
    logic              r_too_long;
    logic              r_op;

    // Home slot arithmetic.
    logic [PW-1:0]     r_prod;
    logic [SUM_W-1:0]  quot;
    logic [SUM_W-1:0]  rem_full;
    logic [SW-1:0]     r_home;

    // Probe state.
    logic [SW-1:0]     r_slot;
    logic [SW-1:0]     r_cnt;
    logic [LW-1:0]     r_idx;
    logic [LW-1:0]     n_idx;
    t_status           r_status;

    // Table: valid flags in flip-flops, lengths and characters in memories.
    logic [SLOTS-1:0]  r_valid;
    logic [LW-1:0]     len_mem  [0:(1 << SW)-1];
    logic [CHAR_W-1:0] char_mem [0:(1 << AW)-1];
    logic [LW-1:0]     r_rd_len;
    logic [CHAR_W-1:0] r_rd_char;

    // Output register.
    logic                  r_ovalid;
    t_status               r_ostatus;
    logic [SLOT_OUT_W-1:0] r_oslot;
    logic [SLOT_OUT_W-1:0] r_ohome;
    logic                  out_free;
    logic                  req_acc;
    logic                  hit;

    shtlp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctl   (ctl)
    );

    // No request is taken while reset is held.
    assign i_req.ready    = ctl.accept && i_rst_n;
    assign req_acc        = i_req.valid && i_req.ready;
    assign out_free       = !r_ovalid || o_rsp.ready;

    assign o_rsp.valid    = r_ovalid;
    assign o_rsp.status   = r_ostatus;
    assign o_rsp.slot     = r_oslot;
    assign o_rsp.home_key = r_ohome;

    assign quot     = r_prod[SH +: SUM_W];
    assign rem_full = r_sum - quot * SLOTS_S;
    assign hit      = (r_status == ST_INSERTED) || (r_status == ST_FOUND);

    always_comb begin
        flags.acc_last  = req_acc && i_req.last_char;
        flags.too_long  = r_too_long;
        flags.op_search = r_op;
        flags.slot_free = !r_valid[r_slot];
        flags.wrap      = (r_cnt == LAST_SLOT);
        flags.len_ne    = (r_rd_len != r_len);
        flags.char_ne   = (r_rd_char != r_buf[r_idx]);
        flags.idx_end   = (LW'(r_idx + 1'b1) == r_len);
        flags.out_free  = out_free;
    end

    always_comb begin
        if (ctl.start || ctl.idx_clr) begin
            n_idx = '0;
        end else if (ctl.idx_inc) begin
            n_idx = LW'(r_idx + 1'b1);
        end else begin
            n_idx = r_idx;
        end
    end

    // Character intake and name state. Characters past the length limit are
    // dropped and only mark the name as too long. Loading a result clears the
    // name so that the next request starts a new one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_sum      <= '0;
            r_too_long <= 1'b0;
        end else if (req_acc) begin
            if (r_len < MAX_LEN) begin
                r_len <= LW'(r_len + 1'b1);
                r_sum <= r_sum + SUM_W'(i_req.character);
            end else begin
                r_too_long <= 1'b1;
            end
        end else if (ctl.emit && out_free) begin
            r_len      <= '0;
            r_sum      <= '0;
            r_too_long <= 1'b0;
        end
    end

    // The operation of the final character governs the whole name.
    always_ff @(posedge i_clk) begin
        if (req_acc && (r_len < MAX_LEN)) begin
            r_buf[r_len] <= i_req.character;
        end
        if (req_acc && i_req.last_char) begin
            r_op <= i_req.op;
        end
    end

    // Home slot: multiply in one step, subtract in the next.
    always_ff @(posedge i_clk) begin
        if (ctl.mul) begin
            r_prod <= PW'(r_sum) * PW'(RECIP);
        end
        if (ctl.rem) begin
            r_home <= SW'(rem_full);
        end
    end

    // Probe pointer, probe count, character index and latched status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_status <= ST_INSERTED;
        end else begin
            r_idx <= n_idx;
            if (ctl.start) begin
                r_slot <= r_home;
                r_cnt  <= '0;
            end else if (ctl.adv) begin
                r_slot <= (r_slot == LAST_SLOT) ? '0 : SW'(r_slot + 1'b1);
                r_cnt  <= SW'(r_cnt + 1'b1);
            end
            if (ctl.st_load) begin
                r_status <= ctl.st;
            end
        end
    end

    // Occupancy flags: set on the copy into a free slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (ctl.wr) begin
            r_valid[r_slot] <= 1'b1;
        end
    end

    // Stored names and lengths. Both memories are read every cycle at the
    // probe slot; the character is read at the next character index so it is ready for the compare.
    always_ff @(posedge i_clk) begin
        if (ctl.wr) begin
            char_mem[{r_slot, r_idx}] <= r_buf[r_idx];
            len_mem[r_slot]           <= r_len;
        end
        r_rd_char <= char_mem[{r_slot, n_idx}];
        r_rd_len  <= len_mem[r_slot];
    end

    // Result register: loaded once the previous result has been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ctl.emit && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit && out_free) begin
            r_ostatus <= r_status;
            r_oslot   <= hit ? SLOT_OUT_W'(r_slot) : '0;
            r_ohome   <= SLOT_OUT_W'(r_home);
        end
    end

endmodule

>>> bench/string_hash_table_linear_probe_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the linear-probe name hash table: drives names
// byte by byte over the request channel and checks every result against a
// predictor. Depends on shtlp_pkg, shtlp_if and the block's top level.
module string_hash_table_linear_probe_tb;
    import shtlp_pkg::*;

    localparam int SLOTS        = 10;
    localparam int MAX_NAME_LEN = 19;

    // Only the op carried by the final byte of a name matters to the block.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam int TARGET_BYTES = 1250;
    localparam int IDLE_PCT     = 22;
    localparam int POOL_N       = 24;
    localparam int POOL_W       = 32;
    // The longest search probes every slot and compares bytes at each one,
    // after the home-slot arithmetic.
    localparam int TAIL_CYCLES  = 250;
    localparam int CYCLE_LIMIT  = 500000;
    // Requests accepted inside this window see no idling on either side.
    localparam int CALM_FIRST   = 500;
    localparam int CALM_LAST    = 750;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
        logic       last;
        logic       drain;   // hold this byte back until no result is awaited
    } t_name_byte;

    typedef struct packed {
        t_status    status;
        logic [5:0] slot;
        logic [5:0] home_key;
    } t_lookup_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    shtlp_req_if name_req ();
    shtlp_rsp_if name_rsp ();

    string_hash_table_linear_probe #(
        .SLOTS        (SLOTS),
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (name_req),
        .o_rsp   (name_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Request bytes still to be sent, and results the block still owes us.
    t_name_byte     byte_queue[$];
    t_lookup_result awaited_results[$];

    int n_queued   = 0;
    int n_accepted = 0;
    int n_errors   = 0;
    int n_cycles   = 0;
    logic calm;

    assign calm = (n_accepted >= CALM_FIRST) && (n_accepted < CALM_LAST);

    // Predictor state: the name being assembled and the table contents.
    logic [12:0] name_sum;
    logic [7:0]  name_bytes [MAX_NAME_LEN];
    int          name_len;
    logic        name_overflow;
    logic        slot_used  [SLOTS];
    logic [7:0]  slot_name  [SLOTS][MAX_NAME_LEN];
    int          slot_len   [SLOTS];
    logic [5:0]  slot_home  [SLOTS];

    // Name pool for the random part. The second half holds near misses of
    // the first half so that searches hit length and byte mismatches.
    logic [7:0] pool_chars [POOL_N][POOL_W];
    int         pool_len   [POOL_N];

    // Advances the predictor by one accepted byte. A final byte hashes the
    // name, runs the probe and queues the one result that the block owes.
    function automatic void probe_table(input logic op, input logic [7:0] ch,
                                        input logic last);
        t_lookup_result r;
        int             home;
        int             idx;
        logic           same;
        if (name_len < MAX_NAME_LEN) begin
            name_bytes[name_len] = ch;
            name_len             = name_len + 1;
            name_sum             = name_sum + {5'd0, ch};
        end else begin
            // Bytes past the maximum length are dropped but poison the name.
            name_overflow = 1'b1;
        end
        if (!last) begin
            return;
        end
        home       = name_sum % SLOTS;
        r.home_key = 6'(home);
        r.slot     = '0;
        if (name_overflow) begin
            r.status = ST_TOO_LONG;
        end else if (op == OP_INSERT) begin
            // First free slot at or after home, wrapping; none means full.
            r.status = ST_FULL;
            idx      = home;
            for (int n = 0; n < SLOTS; n++) begin
                if (!slot_used[idx]) begin
                    slot_used[idx] = 1'b1;
                    for (int k = 0; k < name_len; k++) begin
                        slot_name[idx][k] = name_bytes[k];
                    end
                    slot_len[idx]  = name_len;
                    slot_home[idx] = 6'(home);
                    r.status       = ST_INSERTED;
                    r.slot         = 6'(idx);
                    break;
                end
                idx = (idx + 1) % SLOTS;
            end
        end else begin
            // A free slot ends the search early; otherwise at most one lap.
            r.status = ST_NOT_FOUND;
            idx      = home;
            for (int n = 0; n < SLOTS; n++) begin
                if (!slot_used[idx]) begin
                    break;
                end
                same = (slot_len[idx] == name_len);
                for (int k = 0; k < name_len; k++) begin
                    if (same && slot_name[idx][k] != name_bytes[k]) begin
                        same = 1'b0;
                    end
                end
                if (same) begin
                    r.status = ST_FOUND;
                    r.slot   = 6'(idx);
                    break;
                end
                idx = (idx + 1) % SLOTS;
            end
        end
        awaited_results.push_back(r);
        name_sum      = '0;
        name_len      = 0;
        name_overflow = 1'b0;
    endfunction

    task automatic push_byte(input logic op, input logic [7:0] ch, input logic last,
                             input logic drain);
        t_name_byte nb;
        nb.op    = op;
        nb.ch    = ch;
        nb.last  = last;
        nb.drain = drain;
        byte_queue.push_back(nb);
        n_queued++;
    endtask

    // Sends one pool name. The ops of the inner bytes are random since only
    // the op of the final byte is meant to count.
    task automatic push_name(input int pidx, input logic op, input logic drain);
        logic is_last;
        for (int k = 0; k < pool_len[pidx]; k++) begin
            is_last = (k == pool_len[pidx] - 1);
            push_byte(is_last ? op : logic'($urandom_range(0, 1)), pool_chars[pidx][k],
                      is_last, drain && (k == 0));
        end
    endtask

    function automatic logic [7:0] random_char();
        // A zero byte now and then; the hash treats it like any other byte.
        if ($urandom_range(0, 63) == 0) begin
            return 8'h00;
        end
        return 8'($urandom_range(1, 255));
    endfunction

    // Request driver. The byte at the head of the queue goes out when the
    // channel is free, unless this cycle idles or the byte waits for a drain.
    always @(posedge i_clk) begin : drive_requests
        t_name_byte nb;
        logic       taken;
        if (!i_rst_n) begin
            name_req.valid <= 1'b0;
        end else begin
            taken = name_req.valid && name_req.ready;
            if (taken) begin
                probe_table(name_req.op, name_req.character, name_req.last_char);
                n_accepted++;
            end
            if (!name_req.valid || taken) begin
                if (byte_queue.size() != 0
                    && !(byte_queue[0].drain && awaited_results.size() != 0)
                    && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nb                 = byte_queue.pop_front();
                    name_req.valid     <= 1'b1;
                    name_req.op        <= nb.op;
                    name_req.character <= nb.ch;
                    name_req.last_char <= nb.last;
                end else begin
                    name_req.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Every accepted result must match the oldest awaited
    // one field by field; ready idles at random outside the calm window.
    always @(posedge i_clk) begin : check_results
        t_lookup_result want;
        if (!i_rst_n) begin
            name_rsp.ready <= 1'b0;
        end else begin
            if (name_rsp.valid && name_rsp.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with none awaited: status %0d slot %0d home_key %0d",
                           name_rsp.status, name_rsp.slot, name_rsp.home_key);
                    n_errors++;
                end else begin
                    want = awaited_results.pop_front();
                    if (name_rsp.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, name_rsp.status);
                        n_errors++;
                    end
                    if (name_rsp.slot !== want.slot) begin
                        $error("slot: expected %0d, actual %0d", want.slot, name_rsp.slot);
                        n_errors++;
                    end
                    if (name_rsp.home_key !== want.home_key) begin
                        $error("home_key: expected %0d, actual %0d",
                               want.home_key, name_rsp.home_key);
                        n_errors++;
                    end
                end
            end
            name_rsp.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int   pidx;
        int   base;
        int   r;
        logic op;
        i_rst_n            = 1'b0;
        name_req.valid     = 1'b0;
        name_req.op        = OP_INSERT;
        name_req.character = '0;
        name_req.last_char = 1'b0;
        name_rsp.ready     = 1'b0;
        name_sum           = '0;
        name_len           = 0;
        name_overflow      = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            slot_used[s] = 1'b0;
        end

        // Directed part. Home slots are byte sums modulo ten, so 'A' (65)
        // and 0xFF (255) both land on slot five and collide.
        push_byte(OP_SEARCH, 8'h41, 1'b1, 1'b0);  // empty table, stops at once
        push_byte(OP_INSERT, 8'h41, 1'b1, 1'b0);  // lands in its home slot
        push_byte(OP_SEARCH, 8'h41, 1'b1, 1'b0);  // found at home
        push_byte(OP_INSERT, 8'h41, 1'b1, 1'b0);  // duplicate goes one further
        push_byte(OP_INSERT, 8'hFF, 1'b1, 1'b0);  // probes past two entries
        push_byte(OP_SEARCH, 8'hFF, 1'b1, 1'b0);  // skips byte mismatches
        // Op changes inside the name; the final byte asks for an insert.
        push_byte(OP_SEARCH, 8'h80, 1'b0, 1'b0);
        push_byte(OP_INSERT, 8'h01, 1'b1, 1'b0);  // sum 129, top slot
        push_byte(OP_INSERT, 8'h13, 1'b1, 1'b0);  // home is the top slot, wraps
        push_byte(OP_SEARCH, 8'h13, 1'b1, 1'b1);  // search that wraps, drained
        // A name one byte too long, with a zero byte inside it.
        for (int k = 0; k <= MAX_NAME_LEN; k++) begin
            push_byte(OP_INSERT, (k == 3) ? 8'h00 : 8'($urandom_range(1, 255)),
                      k == MAX_NAME_LEN, 1'b0);
        end

        // Build the pool: mostly short names, one at the maximum length and
        // a few that are too long; at least one is at the maximum length.
        for (int i = 0; i < POOL_N / 2; i++) begin
            r = $urandom_range(0, 9);
            if (i == 0) begin
                pool_len[i] = MAX_NAME_LEN;
            end else if (i == 1) begin
                pool_len[i] = MAX_NAME_LEN + 1;
            end else if (r < 6) begin
                pool_len[i] = $urandom_range(1, 5);
            end else if (r < 8) begin
                pool_len[i] = $urandom_range(6, 12);
            end else if (r < 9) begin
                pool_len[i] = $urandom_range(13, MAX_NAME_LEN);
            end else begin
                pool_len[i] = $urandom_range(MAX_NAME_LEN + 1, MAX_NAME_LEN + 6);
            end
            for (int k = 0; k < POOL_W; k++) begin
                pool_chars[i][k] = random_char();
            end
        end
        for (int i = POOL_N / 2; i < POOL_N; i++) begin
            base        = i - POOL_N / 2;
            pool_len[i] = pool_len[base];
            for (int k = 0; k < POOL_W; k++) begin
                pool_chars[i][k] = pool_chars[base][k];
            end
            r = $urandom_range(0, 2);
            if (r == 0 || (r == 1 && pool_len[i] == 1)) begin
                // Same length, one byte different.
                pidx                = $urandom_range(0, pool_len[i] - 1);
                pool_chars[i][pidx] = pool_chars[i][pidx] ^ 8'($urandom_range(1, 255));
            end else if (r == 1) begin
                pool_len[i] = pool_len[i] - 1;
            end else begin
                // One byte longer; the stored bytes past the old end are random.
                pool_len[i] = pool_len[i] + 1;
            end
        end

        // Random part. Inserts are the minority since the table fills after
        // a handful; the first random name waits until the table is quiet.
        base = 1;
        while (n_queued < TARGET_BYTES) begin
            pidx = $urandom_range(0, POOL_N - 1);
            op   = ($urandom_range(0, 99) < 20) ? OP_INSERT : OP_SEARCH;
            push_name(pidx, op, base != 0 || $urandom_range(0, 39) == 0);
            base = 0;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_queue.size() != 0 || name_req.valid) begin
            @(posedge i_clk);
        end
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && awaited_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
